### hdl/hlts_pkg.sv
// hlts_pkg: widths, register indexes, microcode format and program, and the
// tanh table generator for the filter and soft clipper core.
// No dependencies.
package hlts_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_HP_B0       = 3'd0;
    localparam cfg_idx_t REG_HP_B1       = 3'd1;
    localparam cfg_idx_t REG_HP_A1       = 3'd2;
    localparam cfg_idx_t REG_LP_B0       = 3'd3;
    localparam cfg_idx_t REG_LP_B1       = 3'd4;
    localparam cfg_idx_t REG_LP_A1       = 3'd5;
    localparam cfg_idx_t REG_DRIVE_GAIN  = 3'd6;
    localparam cfg_idx_t REG_DRIVE_RECIP = 3'd7;

    // register formats
    localparam int COEF_W    = 24;
    localparam int COEF_FRAC = 22;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 12;
    localparam int RECIP_W   = 17;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [GAIN_W-1:0]        gain_t;
    typedef logic [RECIP_W-1:0]       recip_t;

    localparam coef_t  HP_B0_RST = 24'sh400000;
    localparam coef_t  HP_B1_RST = 24'shC00000;
    localparam coef_t  COEF_ZERO = 24'sh000000;
    localparam coef_t  LP_B0_RST = 24'sh400000;
    localparam gain_t  GAIN_ONE  = 16'd4096;
    localparam recip_t RECIP_ONE = 17'd65536;

    // shared multiplier, coefficient side
    localparam int MUL_A_W = 32;

    // tanh table: entry k is tanh(8k/depth) in Q.30
    localparam int TANH_DEPTH = 256;
    localparam int TAB_AW     = $clog2(TANH_DEPTH + 1);
    localparam int T_FRAC     = 30;
    localparam int TE_W       = T_FRAC;
    localparam int T_W        = T_FRAC + 1;
    localparam int FRAC_W     = 16;
    localparam int EXP_TERMS  = 24;
    localparam int EXP_SPAN   = 16;

    typedef logic [TE_W-1:0] tentry_t;
    typedef logic [T_W-1:0]  tval_t;

    localparam tval_t       T_ONE   = T_W'(1) << T_FRAC;
    localparam logic [63:0] Q32_ONE = 64'd1 << 32;

    // microcode fields
    typedef logic [3:0] asel_t;
    typedef logic [3:0] bsel_t;
    typedef logic [1:0] accop_t;
    typedef logic [3:0] act_t;
    typedef logic [1:0] jmp_t;

    localparam int PC_W     = 5;
    localparam int PROG_LEN = 24;
    typedef logic [PC_W-1:0] pc_t;

    localparam asel_t A_NONE  = 4'd0;
    localparam asel_t A_HP_B0 = 4'd1;
    localparam asel_t A_HP_B1 = 4'd2;
    localparam asel_t A_HP_A1 = 4'd3;
    localparam asel_t A_LP_B0 = 4'd4;
    localparam asel_t A_LP_B1 = 4'd5;
    localparam asel_t A_LP_A1 = 4'd6;
    localparam asel_t A_GAIN  = 4'd7;
    localparam asel_t A_DIFF  = 4'd8;
    localparam asel_t A_TVAL  = 4'd9;

    localparam bsel_t B_NONE    = 4'd0;
    localparam bsel_t B_X       = 4'd1;
    localparam bsel_t B_HP_PIN  = 4'd2;
    localparam bsel_t B_HP_POUT = 4'd3;
    localparam bsel_t B_LP_PIN  = 4'd4;
    localparam bsel_t B_LP_POUT = 4'd5;
    localparam bsel_t B_MAG     = 4'd6;
    localparam bsel_t B_FRAC    = 4'd7;
    localparam bsel_t B_RECIP   = 4'd8;

    localparam accop_t ACC_HOLD = 2'd0;
    localparam accop_t ACC_LOAD = 2'd1;
    localparam accop_t ACC_ADD  = 2'd2;

    localparam act_t ACT_NONE     = 4'd0;
    localparam act_t ACT_HP_DONE  = 4'd1;
    localparam act_t ACT_LP_DONE  = 4'd2;
    localparam act_t ACT_MAG      = 4'd3;
    localparam act_t ACT_POS      = 4'd4;
    localparam act_t ACT_ADDR_INC = 4'd5;
    localparam act_t ACT_E0       = 4'd6;
    localparam act_t ACT_DIFF     = 4'd7;
    localparam act_t ACT_TINT     = 4'd8;
    localparam act_t ACT_TSAT     = 4'd9;
    localparam act_t ACT_OUT      = 4'd10;

    localparam jmp_t J_NEXT   = 2'd0;
    localparam jmp_t J_SAT    = 2'd1;
    localparam jmp_t J_ALWAYS = 2'd2;
    localparam jmp_t J_END    = 2'd3;

    localparam pc_t PC_TSAT  = 5'd23;
    localparam pc_t PC_SCALE = 5'd20;
    localparam pc_t PC_NONE  = 5'd0;

    typedef struct packed {
        asel_t  a_sel;
        bsel_t  b_sel;
        accop_t acc_op;
        act_t   act;
        jmp_t   jmp;
        pc_t    target;
    } ucode_t;

    // program: a product is registered one step after its operands are
    // selected, so the accumulate that uses it sits on the following step
    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        case (pc)
            // high-pass section
            5'd0:  w = '{A_HP_B0, B_X,       ACC_HOLD, ACT_NONE,     J_NEXT,   PC_NONE};
            5'd1:  w = '{A_HP_B1, B_HP_PIN,  ACC_LOAD, ACT_NONE,     J_NEXT,   PC_NONE};
            5'd2:  w = '{A_HP_A1, B_HP_POUT, ACC_ADD,  ACT_NONE,     J_NEXT,   PC_NONE};
            5'd3:  w = '{A_NONE,  B_NONE,    ACC_ADD,  ACT_NONE,     J_NEXT,   PC_NONE};
            5'd4:  w = '{A_NONE,  B_NONE,    ACC_HOLD, ACT_HP_DONE,  J_NEXT,   PC_NONE};
            // low-pass section, fed from the new high-pass output
            5'd5:  w = '{A_LP_B0, B_HP_POUT, ACC_HOLD, ACT_NONE,     J_NEXT,   PC_NONE};
            5'd6:  w = '{A_LP_B1, B_LP_PIN,  ACC_LOAD, ACT_NONE,     J_NEXT,   PC_NONE};
            5'd7:  w = '{A_LP_A1, B_LP_POUT, ACC_ADD,  ACT_NONE,     J_NEXT,   PC_NONE};
            5'd8:  w = '{A_NONE,  B_NONE,    ACC_ADD,  ACT_NONE,     J_NEXT,   PC_NONE};
            5'd9:  w = '{A_NONE,  B_NONE,    ACC_HOLD, ACT_LP_DONE,  J_NEXT,   PC_NONE};
            // drive scaling and table position
            5'd10: w = '{A_NONE,  B_NONE,    ACC_HOLD, ACT_MAG,      J_NEXT,   PC_NONE};
            5'd11: w = '{A_GAIN,  B_MAG,     ACC_HOLD, ACT_NONE,     J_NEXT,   PC_NONE};
            5'd12: w = '{A_NONE,  B_NONE,    ACC_LOAD, ACT_NONE,     J_NEXT,   PC_NONE};
            5'd13: w = '{A_NONE,  B_NONE,    ACC_HOLD, ACT_POS,      J_NEXT,   PC_NONE};
            5'd14: w = '{A_NONE,  B_NONE,    ACC_HOLD, ACT_ADDR_INC, J_SAT,    PC_TSAT};
            // table interpolation
            5'd15: w = '{A_NONE,  B_NONE,    ACC_HOLD, ACT_E0,       J_NEXT,   PC_NONE};
            5'd16: w = '{A_NONE,  B_NONE,    ACC_HOLD, ACT_DIFF,     J_NEXT,   PC_NONE};
            5'd17: w = '{A_DIFF,  B_FRAC,    ACC_HOLD, ACT_NONE,     J_NEXT,   PC_NONE};
            5'd18: w = '{A_NONE,  B_NONE,    ACC_LOAD, ACT_NONE,     J_NEXT,   PC_NONE};
            5'd19: w = '{A_NONE,  B_NONE,    ACC_HOLD, ACT_TINT,     J_NEXT,   PC_NONE};
            // scale by the reciprocal and deliver
            5'd20: w = '{A_TVAL,  B_RECIP,   ACC_HOLD, ACT_NONE,     J_NEXT,   PC_NONE};
            5'd21: w = '{A_NONE,  B_NONE,    ACC_LOAD, ACT_NONE,     J_NEXT,   PC_NONE};
            5'd22: w = '{A_NONE,  B_NONE,    ACC_HOLD, ACT_OUT,      J_END,    PC_NONE};
            // position beyond the table: tanh taken as one
            5'd23: w = '{A_NONE,  B_NONE,    ACC_HOLD, ACT_TSAT,     J_ALWAYS, PC_SCALE};
            default: w = '{A_NONE, B_NONE,   ACC_HOLD, ACT_NONE,     J_END,    PC_NONE};
        endcase
        return w;
    endfunction

    // unsigned quotient by shift and subtract, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // unsigned Q.32 product
    function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[95:32];
    endfunction

    // e^f for f in [0,1], Q.32, by power series
    function automatic logic [63:0] exp_q32(input logic [63:0] f);
        logic [63:0] term;
        logic [63:0] sum;
        term = Q32_ONE;
        sum  = Q32_ONE;
        for (int i = 1; i <= EXP_TERMS; i++) begin
            term = udiv64(mul_q32(term, f), 64'(i));
            sum  = sum + term;
        end
        return sum;
    endfunction

    // tanh(x) = 1 - 2/(e^2x + 1), with e^2x split into whole and fraction parts
    function automatic tentry_t tanh_entry(input int k);
        logic [63:0] e1;
        logic [63:0] num;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] en;
        logic [63:0] big;
        logic [63:0] den;
        logic [63:0] c;
        e1  = exp_q32(Q32_ONE);
        num = 64'(EXP_SPAN) * 64'(k);
        n   = num >> $clog2(TANH_DEPTH);
        f   = ((num & 64'(TANH_DEPTH - 1)) << 32) >> $clog2(TANH_DEPTH);
        en  = Q32_ONE;
        for (int j = 0; j < EXP_SPAN; j++) begin
            if (64'(j) < n) begin
                en = mul_q32(en, e1);
            end
        end
        big = mul_q32(en, exp_q32(f));
        den = big + Q32_ONE;
        c   = udiv64((64'd1 << 63) + (den >> 1), den);
        return TE_W'((64'd1 << T_FRAC) - c);
    endfunction

endpackage

### hdl/hpf_lpf_tanh_saturator_core.sv
// hpf_lpf_tanh_saturator_core: high-pass and low-pass first-order sections and
// a tanh soft clipper, run by a microcoded sequencer over one shared multiplier.
// Depends on hlts_pkg (microcode program, formats, tanh table generator).
//
//  channel   direction  handshake              payload
//  cfg       in         cfg_write              cfg_index, cfg_data
//  in        in         in_valid / in_stall    audio_in
//  out       out        out_valid / out_stall  audio_out
//
// Each item runs the program from acceptance until its result is registered,
// skipping the interpolation steps when the scaled magnitude lies beyond the
// tanh table; the 24-entry program time-shares the single multiplier and
// accumulator, and the next item can be taken in the cycle after the last step.
// in_stall is high while an item is at work; the next item is taken while
// a finished result still waits in the output register.
// A full output register holds the program at its last step until taken.
// Reset restores the register defaults and clears the filter state.
module hpf_lpf_tanh_saturator_core #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  hlts_pkg::cfg_idx_t                   cfg_index,
    input  logic [hlts_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]       audio_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]       audio_out
);
    import hlts_pkg::*;

    localparam int IW      = SAMPLE_WIDTH + 2;
    localparam int MB_W    = SAMPLE_WIDTH + 3;
    localparam int PROD_W  = MUL_A_W + MB_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int M_W     = SAMPLE_WIDTH + 5;
    localparam int POS_W   = M_W + TAB_AW;
    localparam int IDX_W   = POS_W - IW;
    localparam int OUT_SH  = 46 - (SAMPLE_WIDTH - 1);

    localparam logic signed [ACC_W-1:0] FILT_HALF = ACC_W'(1) << (COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] TINT_HALF = ACC_W'(1) << (FRAC_W - 1);
    localparam logic signed [ACC_W-1:0] OUT_HALF  = ACC_W'(1) << (OUT_SH - 1);
    localparam logic signed [ACC_W-1:0] IW_MAX =
        {{(ACC_W-IW+1){1'b0}}, {(IW-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] IW_MIN =
        {{(ACC_W-IW+1){1'b1}}, {(IW-1){1'b0}}};
    localparam logic [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    // configuration registers
    coef_t  hp_b0_reg, hp_b1_reg, hp_a1_reg;
    coef_t  lp_b0_reg, lp_b1_reg, lp_a1_reg;
    gain_t  drive_gain_reg;
    recip_t drive_recip_reg;

    // filter state
    logic signed [SAMPLE_WIDTH-1:0] hp_prev_in_reg;
    logic signed [IW-1:0]           hp_prev_out_reg;
    logic signed [IW-1:0]           lp_prev_in_reg;
    logic signed [IW-1:0]           lp_prev_out_reg;

    // sequencer
    logic   busy_reg, busy_next;
    pc_t    pc_reg, pc_next;
    logic   out_valid_reg, out_valid_next;
    ucode_t ucw;
    logic   out_free;
    logic   step_en;
    logic   accept;

    // datapath
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [MUL_A_W-1:0]      a_opnd;
    logic signed [MB_W-1:0]         b_opnd;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic [IW-1:0]                  mag_reg;
    logic                           neg_reg;
    logic                           sat_reg;
    logic [FRAC_W-1:0]              fr_reg;
    logic [TAB_AW-1:0]              addr_reg;
    tentry_t                        rom_q_reg;
    tentry_t                        e0_reg;
    logic signed [TE_W:0]           diff_reg;
    tval_t                          t_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_reg;

    logic signed [ACC_W-1:0]        prod_ext;
    logic signed [ACC_W-1:0]        filt_sum;
    logic signed [ACC_W-1:0]        filt_shr;
    logic signed [IW-1:0]           filt_sat;
    gain_t                          gain_eff;
    recip_t                         recip_eff;
    logic [IW-1:0]                  lp_mag;
    logic [M_W-1:0]                 m_val;
    logic [POS_W-1:0]               pos_val;
    logic [IDX_W-1:0]               idx_val;
    logic                           idx_sat;
    logic signed [ACC_W-1:0]        tint_sum;
    logic signed [ACC_W-1:0]        tint_shr;
    logic signed [ACC_W-1:0]        t_sum;
    logic signed [ACC_W-1:0]        out_sum;
    logic [SAMPLE_WIDTH-1:0]        out_mag;
    logic [SAMPLE_WIDTH-1:0]        out_word;
    logic signed [TE_W:0]           diff_val;

    tentry_t tanh_rom [0:TANH_DEPTH];

    // tanh table, worked out at elaboration
    for (genvar k = 0; k <= TANH_DEPTH; k++) begin : g_tanh
        localparam tentry_t ENTRY = tanh_entry(k);
        assign tanh_rom[k] = ENTRY;
    end

    // handshake
    assign accept    = in_valid && !busy_reg;
    assign in_stall  = busy_reg;
    assign out_valid = out_valid_reg;
    assign audio_out = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // control word for the current step
    assign ucw     = ucode_rom(pc_reg);
    assign step_en = busy_reg && ((ucw.act != ACT_OUT) || out_free);

    // step counter and jumps
    always_comb
    begin
        pc_next        = pc_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
        end
        else if (step_en)
        begin
            if (ucw.act == ACT_OUT)
            begin
                out_valid_next = 1'b1;
            end
            case (ucw.jmp)
                J_NEXT:   pc_next = pc_reg + 1'b1;
                J_SAT:    pc_next = sat_reg ? ucw.target : pc_reg + 1'b1;
                J_ALWAYS: pc_next = ucw.target;
                J_END:
                begin
                    pc_next   = '0;
                    busy_next = 1'b0;
                end
                default:  pc_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // effective drive and reciprocal
    always_comb
    begin
        if (drive_gain_reg < GAIN_ONE)
        begin
            gain_eff  = GAIN_ONE;
            recip_eff = RECIP_ONE;
        end
        else
        begin
            gain_eff  = drive_gain_reg;
            recip_eff = (drive_recip_reg > RECIP_ONE) ? RECIP_ONE : drive_recip_reg;
        end
    end

    // multiplier operand selection
    always_comb
    begin
        case (ucw.a_sel)
            A_HP_B0: a_opnd = {{(MUL_A_W-COEF_W){hp_b0_reg[COEF_W-1]}}, hp_b0_reg};
            A_HP_B1: a_opnd = {{(MUL_A_W-COEF_W){hp_b1_reg[COEF_W-1]}}, hp_b1_reg};
            A_HP_A1: a_opnd = {{(MUL_A_W-COEF_W){hp_a1_reg[COEF_W-1]}}, hp_a1_reg};
            A_LP_B0: a_opnd = {{(MUL_A_W-COEF_W){lp_b0_reg[COEF_W-1]}}, lp_b0_reg};
            A_LP_B1: a_opnd = {{(MUL_A_W-COEF_W){lp_b1_reg[COEF_W-1]}}, lp_b1_reg};
            A_LP_A1: a_opnd = {{(MUL_A_W-COEF_W){lp_a1_reg[COEF_W-1]}}, lp_a1_reg};
            A_GAIN:  a_opnd = {{(MUL_A_W-GAIN_W){1'b0}}, gain_eff};
            A_DIFF:  a_opnd = {{(MUL_A_W-TE_W-1){diff_reg[TE_W]}}, diff_reg};
            A_TVAL:  a_opnd = {{(MUL_A_W-T_W){1'b0}}, t_reg};
            default: a_opnd = '0;
        endcase
    end

    always_comb
    begin
        case (ucw.b_sel)
            B_X:       b_opnd = {{(MB_W-SAMPLE_WIDTH){x_reg[SAMPLE_WIDTH-1]}}, x_reg};
            B_HP_PIN:  b_opnd = {{(MB_W-SAMPLE_WIDTH){hp_prev_in_reg[SAMPLE_WIDTH-1]}},
                                 hp_prev_in_reg};
            B_HP_POUT: b_opnd = {hp_prev_out_reg[IW-1], hp_prev_out_reg};
            B_LP_PIN:  b_opnd = {lp_prev_in_reg[IW-1], lp_prev_in_reg};
            B_LP_POUT: b_opnd = {lp_prev_out_reg[IW-1], lp_prev_out_reg};
            B_MAG:     b_opnd = {1'b0, mag_reg};
            B_FRAC:    b_opnd = {{(MB_W-FRAC_W){1'b0}}, fr_reg};
            B_RECIP:   b_opnd = {{(MB_W-RECIP_W){1'b0}}, recip_eff};
            default:   b_opnd = '0;
        endcase
    end

    // filter rounding and saturation to the internal width
    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign filt_sum = acc_reg + FILT_HALF;
    assign filt_shr = filt_sum >>> COEF_FRAC;

    always_comb
    begin
        if (filt_shr > IW_MAX)
        begin
            filt_sat = IW_MAX[IW-1:0];
        end
        else if (filt_shr < IW_MIN)
        begin
            filt_sat = IW_MIN[IW-1:0];
        end
        else
        begin
            filt_sat = filt_shr[IW-1:0];
        end
    end

    // magnitude, table position and interpolation arithmetic
    assign lp_mag   = lp_prev_out_reg[IW-1] ? (~lp_prev_out_reg + 1'b1) : lp_prev_out_reg;
    assign m_val    = acc_reg[GAIN_FRAC +: M_W];
    assign pos_val  = POS_W'(m_val) * POS_W'(TANH_DEPTH);
    assign idx_val  = pos_val[POS_W-1:IW];
    assign idx_sat  = idx_val >= IDX_W'(TANH_DEPTH);
    assign diff_val = $signed({1'b0, rom_q_reg}) - $signed({1'b0, e0_reg});
    assign tint_sum = acc_reg + TINT_HALF;
    assign tint_shr = tint_sum >>> FRAC_W;
    assign t_sum    = $signed({{(ACC_W-TE_W){1'b0}}, e0_reg}) + tint_shr;

    // final scaling, sign, and saturation of positive outputs
    assign out_sum = acc_reg + OUT_HALF;
    assign out_mag = out_sum[OUT_SH +: SAMPLE_WIDTH];

    always_comb
    begin
        if (neg_reg)
        begin
            out_word = ~out_mag + 1'b1;
        end
        else if (out_mag[SAMPLE_WIDTH-1])
        begin
            out_word = OUT_MAX;
        end
        else
        begin
            out_word = out_mag;
        end
    end

    // configuration writes and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_b0_reg       <= HP_B0_RST;
            hp_b1_reg       <= HP_B1_RST;
            hp_a1_reg       <= COEF_ZERO;
            lp_b0_reg       <= LP_B0_RST;
            lp_b1_reg       <= COEF_ZERO;
            lp_a1_reg       <= COEF_ZERO;
            drive_gain_reg  <= GAIN_ONE;
            drive_recip_reg <= RECIP_ONE;
            hp_prev_in_reg  <= '0;
            hp_prev_out_reg <= '0;
            lp_prev_in_reg  <= '0;
            lp_prev_out_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_HP_B0:       hp_b0_reg       <= cfg_data[COEF_W-1:0];
                    REG_HP_B1:       hp_b1_reg       <= cfg_data[COEF_W-1:0];
                    REG_HP_A1:       hp_a1_reg       <= cfg_data[COEF_W-1:0];
                    REG_LP_B0:       lp_b0_reg       <= cfg_data[COEF_W-1:0];
                    REG_LP_B1:       lp_b1_reg       <= cfg_data[COEF_W-1:0];
                    REG_LP_A1:       lp_a1_reg       <= cfg_data[COEF_W-1:0];
                    REG_DRIVE_GAIN:  drive_gain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_DRIVE_RECIP: drive_recip_reg <= cfg_data[RECIP_W-1:0];
                    default:         ;
                endcase
            end
            if (step_en && (ucw.act == ACT_HP_DONE))
            begin
                hp_prev_in_reg  <= x_reg;
                hp_prev_out_reg <= filt_sat;
            end
            if (step_en && (ucw.act == ACT_LP_DONE))
            begin
                lp_prev_in_reg  <= hp_prev_out_reg;
                lp_prev_out_reg <= filt_sat;
            end
        end
    end

    // shared multiplier, accumulator and working registers
    always_ff @(posedge clk)
    begin
        prod_reg  <= a_opnd * b_opnd;
        rom_q_reg <= (addr_reg <= TAB_AW'(TANH_DEPTH)) ? tanh_rom[addr_reg] : '0;
        if (accept)
        begin
            x_reg <= audio_in;
        end
        if (step_en)
        begin
            case (ucw.acc_op)
                ACC_LOAD: acc_reg <= prod_ext;
                ACC_ADD:  acc_reg <= acc_reg + prod_ext;
                default:  acc_reg <= acc_reg;
            endcase
            case (ucw.act)
                ACT_MAG:
                begin
                    mag_reg <= lp_mag;
                    neg_reg <= lp_prev_out_reg[IW-1];
                end
                ACT_POS:
                begin
                    sat_reg  <= idx_sat;
                    fr_reg   <= pos_val[IW-1 -: FRAC_W];
                    addr_reg <= idx_sat ? '0 : idx_val[TAB_AW-1:0];
                end
                ACT_ADDR_INC: addr_reg <= addr_reg + 1'b1;
                ACT_E0:       e0_reg   <= rom_q_reg;
                ACT_DIFF:     diff_reg <= diff_val;
                ACT_TINT:     t_reg    <= t_sum[T_W-1:0];
                ACT_TSAT:     t_reg    <= T_ONE;
                ACT_OUT:      out_reg  <= out_word;
                default:      ;
            endcase
        end
    end

`ifndef SYNTH
    // no step runs while idle: the counter rests at the program start
    a_idle_pc: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (pc_reg == '0))
        else $error("step counter away from start while idle");

    // the counter never leaves the program
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg < pc_t'(PROG_LEN))
        else $error("step counter beyond program");

    // a result appears only from the delivery step
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg && (ucw.act == ACT_OUT)))
        else $error("result raised outside the delivery step");

    // interpolated tanh never exceeds one
    a_tint_range: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && (ucw.act == ACT_TINT)) |=> (t_reg <= T_ONE))
        else $error("interpolated tanh above one");

    // the interpolation steps are skipped for a position beyond the table
    a_sat_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (ucw.act == ACT_E0)) |-> !sat_reg)
        else $error("table read on a saturated position");
`endif

endmodule
